>>> design/gcb_pkg.sv
`default_nettype none

package gcb_pkg;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [8:0] width;
        logic [8:0] height;
    } t_cfg;

    typedef struct packed {
        logic        op;
        logic        clipped;
        logic [15:0] prod;
    } t_cmd;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_LOOK,
        B_DIV,
        B_FIX
    } t_bstate;

    localparam logic [2:0] CFG_RED    = 3'd0;
    localparam logic [2:0] CFG_GREEN  = 3'd1;
    localparam logic [2:0] CFG_BLUE   = 3'd2;
    localparam logic [2:0] CFG_ALPHA  = 3'd3;
    localparam logic [2:0] CFG_WIDTH  = 3'd4;
    localparam logic [2:0] CFG_HEIGHT = 3'd5;

    localparam logic OP_BLEND = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic [7:0]  CH_FULL    = 8'd255;
    localparam logic [15:0] FULL_SCALE = 16'd65025;
    // floor(2^32 / 65025)
    localparam logic [16:0] RECIP      = 17'd66051;

endpackage

`default_nettype wire

>>> design/gcb_fifo.sv
`default_nettype none

module gcb_fifo #(
    parameter int unsigned W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty,
    output logic         o_full
);

    logic [W-1:0] r_slot [2];
    logic         r_wr;
    logic         r_rd;
    logic [1:0]   r_cnt;

    assign o_data  = r_slot[r_rd];
    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'd2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_data;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> !i_push)
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |-> !i_pop)
        else $error("queue pop while empty");
`endif

endmodule

`default_nettype wire

>>> design/gcb_front.sv
`default_nettype none

module gcb_front
    import gcb_pkg::*;
#(
    parameter int unsigned MAX_WIDTH  = 256,
    parameter int unsigned MAX_HEIGHT = 256,
    parameter int unsigned AW         = 16
) (
    input  t_cfg              i_cfg,
    input  logic              i_start,
    input  logic              i_opcode,
    input  logic signed [9:0] i_pixel_x,
    input  logic signed [9:0] i_pixel_y,
    input  logic [7:0]        i_coverage,
    input  logic              i_full,
    input  logic              i_clearing,
    output logic              o_busy,
    output logic              o_push,
    output t_cmd              o_cmd,
    output logic [AW-1:0]     o_addr
);

    localparam int unsigned WW = ($clog2(MAX_WIDTH + 1) > 9) ? $clog2(MAX_WIDTH + 1) : 9;
    localparam int unsigned HW = ($clog2(MAX_HEIGHT + 1) > 9) ? $clog2(MAX_HEIGHT + 1) : 9;
    localparam int unsigned SW = 9 + WW + 1;
    localparam int unsigned IW = (AW > SW) ? AW : SW;

    logic [WW-1:0] w_cfg;
    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_cfg;
    logic [HW-1:0] h_eff;
    logic [8:0]    x9;
    logic [8:0]    y9;
    logic          clip;
    logic [IW-1:0] idx_full;
    logic [15:0]   prod;

    assign w_cfg = WW'(i_cfg.width);
    assign h_cfg = HW'(i_cfg.height);
    assign w_eff = (w_cfg > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : w_cfg;
    assign h_eff = (h_cfg > HW'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : h_cfg;

    assign x9 = i_pixel_x[8:0];
    assign y9 = i_pixel_y[8:0];

    assign clip = i_pixel_x[9] | i_pixel_y[9]
                | (WW'(x9) >= w_eff) | (HW'(y9) >= h_eff);

    assign idx_full = IW'(y9) * IW'(w_eff) + IW'(x9);
    assign prod     = 16'(i_coverage) * 16'(i_cfg.alpha);

    assign o_busy  = i_full | i_clearing;
    assign o_push  = i_start & ~o_busy;
    assign o_addr  = idx_full[AW-1:0];
    assign o_cmd   = '{op: i_opcode, clipped: clip, prod: prod};

endmodule

`default_nettype wire

>>> design/gcb_back.sv
`default_nettype none

module gcb_back
    import gcb_pkg::*;
#(
    parameter int unsigned DEPTH = 65536,
    parameter int unsigned AW    = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cfg          i_cfg,
    input  logic          i_empty,
    input  t_cmd          i_cmd,
    input  logic [AW-1:0] i_addr,
    output logic          o_pop,
    output logic          o_clearing,
    output logic          o_valid,
    output logic          o_clipped,
    output logic [31:0]   o_pixel_value
);

    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    t_bstate       r_state;
    t_bstate       n_state;
    logic [AW-1:0] r_clr_addr;
    logic [AW-1:0] r_addr;
    logic          r_op;
    logic [15:0]   r_prod;
    logic [31:0]   r_rdata;
    logic [31:0]   r_mem [DEPTH];
    logic [23:0]   r_num [4];
    logic [23:0]   n_num [4];
    logic [8:0]    r_q0 [4];
    logic [8:0]    n_q0 [4];
    logic [7:0]    n_res [4];
    logic [7:0]    col_arr [4];
    logic          r_out_valid;
    logic          r_out_clipped;
    logic [31:0]   r_out_pixel;

    logic          pop;
    logic          clearing;
    logic          emit_clip;
    logic          emit_read;
    logic          emit_blend;
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [31:0]   mem_wdata;
    logic [31:0]   blend_px;

    assign col_arr[0] = i_cfg.red;
    assign col_arr[1] = i_cfg.green;
    assign col_arr[2] = i_cfg.blue;
    assign col_arr[3] = CH_FULL;

    for (genvar c = 0; c < 4; c++) begin : g_lane
        logic [7:0]         dst;
        logic signed [8:0]  diff;
        logic signed [26:0] term;
        logic signed [26:0] base;
        logic [40:0]        prodq;
        logic [24:0]        rem;

        assign dst   = r_rdata[8*c +: 8];
        assign diff  = $signed({1'b0, col_arr[c]}) - $signed({1'b0, dst});
        assign term  = 27'(diff) * 27'($signed({1'b0, r_prod}));
        assign base  = $signed(27'(dst) * 27'(FULL_SCALE));
        assign n_num[c] = 24'(term + base);

        assign prodq   = 41'(r_num[c]) * 41'(RECIP);
        assign n_q0[c] = prodq[40:32];

        assign rem      = 25'(r_num[c]) - 25'(r_q0[c]) * 25'(FULL_SCALE);
        assign n_res[c] = (rem >= 25'(FULL_SCALE)) ? 8'(r_q0[c] + 9'd1) : r_q0[c][7:0];
    end

    assign blend_px = {n_res[3], n_res[2], n_res[1], n_res[0]};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_CLEAR: begin
                if (r_clr_addr == LAST) begin
                    n_state = B_IDLE;
                end
            end
            B_IDLE: begin
                if (!i_empty && !i_cmd.clipped) begin
                    n_state = B_LOOK;
                end
            end
            B_LOOK: begin
                n_state = (r_op == OP_BLEND) ? B_DIV : B_IDLE;
            end
            B_DIV:   n_state = B_FIX;
            B_FIX:   n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        pop        = 1'b0;
        clearing   = 1'b0;
        emit_clip  = 1'b0;
        emit_read  = 1'b0;
        emit_blend = 1'b0;
        unique case (r_state)
            B_CLEAR: clearing = 1'b1;
            B_IDLE: begin
                pop       = ~i_empty;
                emit_clip = ~i_empty & i_cmd.clipped;
            end
            B_LOOK:  emit_read  = (r_op == OP_READ);
            B_FIX:   emit_blend = 1'b1;
            default: ;
        endcase
    end

    assign mem_we    = clearing | emit_blend;
    assign mem_addr  = clearing ? r_clr_addr : r_addr;
    assign mem_wdata = clearing ? 32'd0 : blend_px;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= emit_clip | emit_read | emit_blend;
            if (clearing) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_op   <= i_cmd.op;
            r_prod <= i_cmd.prod;
            r_addr <= i_addr;
        end
        if (r_state == B_LOOK) begin
            r_num <= n_num;
        end
        if (r_state == B_DIV) begin
            r_q0 <= n_q0;
        end
        priority if (emit_clip) begin
            r_out_clipped <= 1'b1;
            r_out_pixel   <= 32'd0;
        end else if (emit_read) begin
            r_out_clipped <= 1'b0;
            r_out_pixel   <= r_rdata;
        end else if (emit_blend) begin
            r_out_clipped <= 1'b0;
            r_out_pixel   <= blend_px;
        end else begin
            r_out_clipped <= r_out_clipped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        if (pop) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_pop         = pop;
    assign o_clearing    = clearing;
    assign o_valid       = r_out_valid;
    assign o_clipped     = r_out_clipped;
    assign o_pixel_value = r_out_pixel;

`ifndef SYNTHESIS
    a_quiet_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_CLEAR) |-> !r_out_valid)
        else $error("result during clearing pass");
    a_clip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_clipped) |-> (r_out_pixel == 32'd0))
        else $error("clipped result carries pixel data");
    a_fix_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_FIX) |=> (r_out_valid && !r_out_clipped))
        else $error("blend write without result");
`endif

endmodule

`default_nettype wire

>>> design/glyph_coverage_blend_into_rgba.sv
`default_nettype none

// Glyph coverage blend into an RGBA8 texture of MAX_WIDTH x MAX_HEIGHT pixels.
// Command channel: an item is taken at a clock edge with start high and busy low.
// opcode 0 blends coverage toward the text color, opcode 1 reads a pixel.
// Result channel: o_valid strobes one cycle with o_clipped and o_pixel_value;
// the receiver cannot stall, every result is taken on the cycle it is shown.
// Config port: i_cfg_we writes i_cfg_data to register i_cfg_index at once.
// Path of an item: the queue takes it at the accept edge and the back end pops
//   it when idle; clipped results follow the pop, reads the memory read, blends the write back.
// The back end runs one item at a time through a single-port texture memory:
// a blend holds it through read, multiply, reciprocal, and fix and write back,
// a read through the memory read and its result, a clipped item only through
// its pop. A 2-entry queue in front lets busy stay low until it fills.
// After reset the texture is swept to zero, one pixel a cycle, across all
// MAX_WIDTH*MAX_HEIGHT pixels; busy stays high meanwhile. Config registers
// return to opaque white and 256 x 256 at reset and may be written during the sweep.
module glyph_coverage_blend_into_rgba
    import gcb_pkg::*;
#(
    parameter int unsigned MAX_WIDTH  = 256,
    parameter int unsigned MAX_HEIGHT = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_opcode,
    input  logic signed [9:0] i_pixel_x,
    input  logic signed [9:0] i_pixel_y,
    input  logic [7:0]        i_coverage,
    output logic              o_valid,
    output logic              o_clipped,
    output logic [31:0]       o_pixel_value,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_index,
    input  logic [8:0]        i_cfg_data
);

    localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW    = $bits(t_cmd);
    localparam int unsigned QW    = CW + AW;

    t_cfg          r_cfg;
    logic          push;
    t_cmd          front_cmd;
    logic [AW-1:0] front_addr;
    logic [QW-1:0] q_dout;
    logic          q_empty;
    logic          q_full;
    logic          pop;
    logic          clearing;
    t_cmd          head_cmd;
    logic [AW-1:0] head_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{red: CH_FULL, green: CH_FULL, blue: CH_FULL, alpha: CH_FULL,
                       width: 9'd256, height: 9'd256};
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_RED:    r_cfg.red    <= i_cfg_data[7:0];
                CFG_GREEN:  r_cfg.green  <= i_cfg_data[7:0];
                CFG_BLUE:   r_cfg.blue   <= i_cfg_data[7:0];
                CFG_ALPHA:  r_cfg.alpha  <= i_cfg_data[7:0];
                CFG_WIDTH:  r_cfg.width  <= i_cfg_data;
                CFG_HEIGHT: r_cfg.height <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    gcb_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .AW         (AW)
    ) u_front (
        .i_cfg      (r_cfg),
        .i_start    (start),
        .i_opcode   (i_opcode),
        .i_pixel_x  (i_pixel_x),
        .i_pixel_y  (i_pixel_y),
        .i_coverage (i_coverage),
        .i_full     (q_full),
        .i_clearing (clearing),
        .o_busy     (busy),
        .o_push     (push),
        .o_cmd      (front_cmd),
        .o_addr     (front_addr)
    );

    gcb_fifo #(
        .W (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({front_cmd, front_addr}),
        .i_pop   (pop),
        .o_data  (q_dout),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    assign head_cmd  = t_cmd'(q_dout[QW-1:AW]);
    assign head_addr = q_dout[AW-1:0];

    gcb_back #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_empty       (q_empty),
        .i_cmd         (head_cmd),
        .i_addr        (head_addr),
        .o_pop         (pop),
        .o_clearing    (clearing),
        .o_valid       (o_valid),
        .o_clipped     (o_clipped),
        .o_pixel_value (o_pixel_value)
    );

endmodule

`default_nettype wire
